>>> hw/rtl/psue_pkg.sv
// psue_pkg: shared types and constants for the particle swarm update engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package psue_pkg;
  localparam int NumParticles = 32;
  localparam int NumDims      = 8;
  localparam int PW = $clog2(NumParticles);
  localparam int DW = $clog2(NumDims);
  localparam int AW = PW + DW;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_REPORT = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_INERTIA   = 3'd0,
    REG_COGNITIVE = 3'd1,
    REG_SOCIAL    = 3'd2,
    REG_POS_MIN   = 3'd3,
    REG_POS_MAX   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [4:0]         particle;
    logic [2:0]         dimension;
    logic signed [23:0] load_value;
    logic [31:0]        fitness;
    logic [15:0]        rand_cognitive;
    logic [15:0]        rand_social;
  } in_word_t;

  typedef struct packed {
    logic signed [23:0] position;
    logic signed [23:0] best_component;
    logic [31:0]        best_fitness;
    logic               personal_improved;
    logic               global_improved;
  } out_word_t;

  // Multiply request from the sequencer to the shared multiplier.
  typedef struct packed {
    logic               start;
    logic [31:0]        a;   // unsigned
    logic signed [24:0] b;   // signed
  } mul_req_t;
endpackage
`default_nettype wire

>>> hw/rtl/particle_swarm_update_engine.sv
// particle_swarm_update_engine: top level, sequencer, best registers.
// Depends on psue_pkg, psue_mul, psue_store.
//
//   port group | dir | handshake     | word
//   in_        | in  | valid / stall | psue_pkg::in_word_t
//   out_       | out | valid / stall | psue_pkg::out_word_t
//   cfg_       | in  | valid / ready | index 3b, data 24b
//
// One item at a time. Load and read pass S_RD, S_RDW and S_DONE to a result;
// an update adds two gain products, then three terms through the one shared
// multiplier, and rereads the entry; a fitness report that improves also
// copies every component (a read and a write per component copy).
// in_stall is high while busy; a stalled result holds in the output register
// and the sequencer waits in S_DONE. Sync active-low reset clears control,
// presets gains, clamps and bests; the particle memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module particle_swarm_update_engine (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire psue_pkg::in_word_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output psue_pkg::out_word_t       out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [23:0]          cfg_data
);
  import psue_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_RDW, S_G1, S_G2, S_M0, S_M1, S_M2, S_WAIT, S_ACC, S_FIN,
    S_CP_RD, S_CP_WR, S_DONE
  } state_t;

  state_t state_r;
  in_word_t item_r;
  logic [15:0] w_r, c1_r, c2_r;
  logic signed [23:0] pmin_r, pmax_r;
  logic [31:0] pbf_r [NumParticles];
  logic [31:0] gbf_r;
  logic signed [23:0] gbp_r [NumDims];
  logic signed [59:0] acc_r;
  logic [31:0] g1_r, g2_r;
  logic [DW:0] k_r;
  logic pi_r, gi_r, ok_r, pok_r, dok_r;
  out_word_t res_r;

  logic [AW-1:0] rd_addr, wr_addr;
  logic signed [23:0] x_q, v_q, pb_q, x_in, v_in, pb_in;
  logic wr_x, wr_v, wr_pb;
  mul_req_t mreq;
  logic signed [57:0] prod;

  psue_store u_store (
    .clk, .rd_addr, .x_r(x_q), .v_r(v_q), .pb_r(pb_q),
    .wr_addr, .wr_x, .wr_v, .wr_pb, .x_in, .v_in, .pb_in
  );
  psue_mul u_mul (.clk, .req(mreq), .prod_r(prod));

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_data  = res_r;

  wire [PW-1:0] p_i = item_r.particle[PW-1:0];
  wire [DW-1:0] d_i = item_r.dimension[DW-1:0];
  wire [DW-1:0] k_i = k_r[DW-1:0];
  assign rd_addr = (state_r == S_CP_RD || state_r == S_CP_WR) ? {p_i, k_i} : {p_i, d_i};

  // Velocity math
  wire signed [24:0] dp = 25'(pb_q) - 25'(x_q);
  wire signed [24:0] dg = 25'(gbp_r[d_i]) - 25'(x_q);
  wire signed [35:0] vnew_f = 36'(acc_r >>> 28);
  wire signed [23:0] vsat = (vnew_f > 36'sd8388607) ? 24'sd8388607 :
                            (vnew_f < -36'sd8388608) ? -24'sd8388608 : vnew_f[23:0];
  wire signed [24:0] nx0 = 25'(x_q) + 25'(vsat);
  wire signed [24:0] nx1 = (nx0 < 25'(pmin_r)) ? 25'(pmin_r) : nx0;
  wire signed [24:0] nx  = (nx1 > 25'(pmax_r)) ? 25'(pmax_r) : nx1;

  always_comb begin
    mreq = '0;
    case (state_r)
      S_G1: begin
        mreq.start = 1'b1; mreq.a = 32'(c1_r); mreq.b = 25'(item_r.rand_cognitive);
      end
      S_G2: begin
        mreq.start = 1'b1; mreq.a = 32'(c2_r); mreq.b = 25'(item_r.rand_social);
      end
      S_M0: begin mreq.start = 1'b1; mreq.a = 32'(w_r); mreq.b = 25'(v_q); end
      S_M1: begin mreq.start = 1'b1; mreq.a = g1_r; mreq.b = dp; end
      S_M2: begin mreq.start = 1'b1; mreq.a = g2_r; mreq.b = dg; end
      default: mreq = '0;
    endcase
    wr_addr = {p_i, d_i};
    wr_x = 1'b0; wr_v = 1'b0; wr_pb = 1'b0;
    x_in = item_r.load_value; v_in = '0; pb_in = item_r.load_value;
    if (state_r == S_RD && item_r.command == CMD_LOAD && ok_r) begin
      wr_x = 1'b1; wr_v = 1'b1; wr_pb = 1'b1;
    end else if (state_r == S_FIN) begin
      wr_x = 1'b1; wr_v = 1'b1; x_in = nx[23:0]; v_in = vsat;
    end else if (state_r == S_CP_WR) begin
      wr_addr = {p_i, k_i}; wr_pb = 1'b1; pb_in = x_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; out_valid <= 1'b0;
      w_r <= 16'd2867; c1_r <= 16'd6144; c2_r <= 16'd6144;
      pmin_r <= '0; pmax_r <= 24'sd65536;
      gbf_r <= '1;
      for (int i = 0; i < NumParticles; i++) pbf_r[i] <= '1;
      for (int i = 0; i < NumDims; i++) gbp_r[i] <= '0;
    end else begin
      if (out_valid && !out_stall && state_r != S_DONE) out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_INERTIA:   w_r    <= cfg_data[15:0];
          REG_COGNITIVE: c1_r   <= cfg_data[15:0];
          REG_SOCIAL:    c2_r   <= cfg_data[15:0];
          REG_POS_MIN:   pmin_r <= cfg_data;
          REG_POS_MAX:   pmax_r <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: if (in_valid && !in_stall) begin
          item_r <= in_data;
          pok_r <= 32'(in_data.particle) < NumParticles;
          dok_r <= 32'(in_data.dimension) < NumDims;
          ok_r  <= (32'(in_data.particle) < NumParticles) &&
                   (32'(in_data.dimension) < NumDims);
          pi_r <= 1'b0; gi_r <= 1'b0; acc_r <= '0; k_r <= '0;
          state_r <= S_RD;
        end
        S_RD: state_r <= S_RDW;
        S_RDW: begin
          if (item_r.command == CMD_UPDATE && ok_r) state_r <= S_G1;
          else if (item_r.command == CMD_REPORT && pok_r &&
                   item_r.fitness < pbf_r[p_i]) begin
            pi_r <= 1'b1; pbf_r[p_i] <= item_r.fitness;
            if (item_r.fitness < gbf_r) begin
              gi_r <= 1'b1; gbf_r <= item_r.fitness;
            end
            state_r <= S_CP_RD;
          end else state_r <= S_DONE;
        end
        S_G1: state_r <= S_G2;
        S_G2: state_r <= S_M0;
        S_M0: begin g1_r <= prod[31:0]; state_r <= S_M1; end   // c1*r1 lands
        S_M1: begin g2_r <= prod[31:0]; state_r <= S_M2; end   // c2*r2 lands
        S_M2: begin   // inertia term lands
          acc_r <= acc_r + (60'(prod) <<< 16);
          state_r <= S_WAIT;
        end
        S_WAIT: begin acc_r <= acc_r + 60'(prod); state_r <= S_ACC; end  // cognitive
        S_ACC: begin acc_r <= acc_r + 60'(prod); state_r <= S_FIN; end   // social
        S_FIN: state_r <= S_RD;     // reread updated entry, then report
        S_CP_RD: state_r <= S_CP_WR;
        S_CP_WR: begin
          if (gi_r) gbp_r[k_i] <= x_q;
          if (k_r == (DW+1)'(NumDims - 1)) begin
            k_r <= '0; state_r <= S_RD;
            item_r.command <= CMD_READ;
          end else begin
            k_r <= k_r + 1'b1; state_r <= S_CP_RD;
          end
        end
        S_DONE: if (!out_valid || !out_stall) begin
          res_r.position <= ok_r ? x_q : '0;
          res_r.best_component <= dok_r ? gbp_r[d_i] : '0;
          res_r.best_fitness <= gbf_r;
          res_r.personal_improved <= pi_r;
          res_r.global_improved <= gi_r;
          out_valid <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      if (state_r == S_FIN) item_r.command <= CMD_READ;
    end
  end

  // Busy sequencer never asks the host for more input.
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("input taken while busy");
  a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> out_valid) else $error("result lost");
  a_gi_implies_pi: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.global_improved || out_data.personal_improved))
    else $error("global improvement without personal");
endmodule
`default_nettype wire

>>> hw/rtl/psue_mul.sv
// psue_mul: shared registered multiplier, unsigned 32 x signed 25 bits.
// Depends on psue_pkg.
`timescale 1ns / 1ps
`default_nettype none
module psue_mul (
  input  wire logic                     clk,
  input  wire psue_pkg::mul_req_t       req,
  output logic signed [57:0]            prod_r
);
  import psue_pkg::*;
  // Split 32-bit operand in two 16-bit halves to stay under 32x32 each.
  logic signed [41:0] lo_r, hi_r;
  logic               go_r;

  always_ff @(posedge clk) begin
    lo_r <= $signed({1'b0, req.a[15:0]}) * req.b;
    hi_r <= $signed({1'b0, req.a[31:16]}) * req.b;
    go_r <= req.start;
    if (go_r) begin
      prod_r <= 58'(hi_r) * 58'sd65536 + 58'(lo_r);
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/psue_store.sv
// psue_store: particle state memories (position, velocity, personal best).
// Depends on psue_pkg.
`timescale 1ns / 1ps
`default_nettype none
module psue_store (
  input  wire logic                     clk,
  input  wire logic [psue_pkg::AW-1:0]  rd_addr,
  output logic signed [23:0]            x_r,
  output logic signed [23:0]            v_r,
  output logic signed [23:0]            pb_r,
  input  wire logic [psue_pkg::AW-1:0]  wr_addr,
  input  wire logic                     wr_x,
  input  wire logic                     wr_v,
  input  wire logic                     wr_pb,
  input  wire logic signed [23:0]       x_in,
  input  wire logic signed [23:0]       v_in,
  input  wire logic signed [23:0]       pb_in
);
  import psue_pkg::*;
  localparam int Depth = NumParticles * NumDims;
  logic signed [23:0] xm [Depth];
  logic signed [23:0] vm [Depth];
  logic signed [23:0] pm [Depth];

  always_ff @(posedge clk) begin
    if (wr_x)  xm[wr_addr] <= x_in;
    if (wr_v)  vm[wr_addr] <= v_in;
    if (wr_pb) pm[wr_addr] <= pb_in;
    x_r  <= xm[rd_addr];
    v_r  <= vm[rd_addr];
    pb_r <= pm[rd_addr];
  end
endmodule
`default_nettype wire
